>>> src/bls_pkg.sv
// Shared types and constants for the bounded LIFO stack.
// Used by bls_ctrl, bls_datapath and bounded_lifo_stack; no dependencies.
package bls_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned PD_W   = 32;
  localparam int unsigned RD_W   = 32;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CAP_W  = 8;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_REVERSE = 3'd4
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_OUT,
    ST_HOLD,
    ST_REV_WLO,
    ST_REV_WHI
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic push;        // write push data at count, count + 1
    logic pop_dec;     // count - 1
    logic clear;       // count = 0
    logic rd_top;      // read entry count - 1 on port a
    logic rev_init;    // lo = 0, hi = count - 1, read both
    logic rev_next;    // read lo + 1 and hi - 1
    logic rev_wlo;     // entry[lo] = read b, save read a
    logic rev_whi;     // entry[hi] = saved, step lo/hi inward
    logic load_out;    // capture a result into the output register
    logic out_rd_ram;  // result read data comes from port a
    err_e out_err;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic cnt_gt1;
    logic rev_more;
    logic out_free;
  } sts_t;

endpackage

>>> src/bls_ram.sv
// Generic simple RAM: one write port, two read ports with registered read data.
// No dependencies.
module bls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic                     re_b_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/bls_ctrl.sv
// Controller state machine for the bounded LIFO stack.
// Depends on bls_pkg; drives bls_datapath through bls_pkg::cmd_t.
module bls_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [bls_pkg::OP_W-1:0]   op_i,
  input  bls_pkg::sts_t              sts_i,
  output bls_pkg::cmd_t              cmd_o
);

  bls_pkg::state_e state_q, state_d;
  logic            is_pop_q, is_pop_d;
  bls_pkg::err_e   err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bls_pkg::ST_IDLE;
      is_pop_q <= 1'b0;
      err_q    <= bls_pkg::ERR_OK;
    end else begin
      state_q  <= state_d;
      is_pop_q <= is_pop_d;
      err_q    <= err_d;
    end
  end

  logic          fin;
  bls_pkg::err_e fin_err;

  always_comb begin
    state_d    = state_q;
    is_pop_d   = is_pop_q;
    err_d      = err_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_err = bls_pkg::ERR_OK;
    fin        = 1'b0;
    fin_err    = bls_pkg::ERR_OK;

    unique case (state_q)
      bls_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (bls_pkg::op_e'(op_i))
            bls_pkg::OP_PUSH: begin
              fin = 1'b1;
              if (sts_i.full) begin
                fin_err = bls_pkg::ERR_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            bls_pkg::OP_POP, bls_pkg::OP_PEEK: begin
              if (sts_i.empty) begin
                fin     = 1'b1;
                fin_err = bls_pkg::ERR_EMPTY;
              end else begin
                cmd_o.rd_top = 1'b1;
                is_pop_d     = (bls_pkg::op_e'(op_i) == bls_pkg::OP_POP);
                state_d      = bls_pkg::ST_POP_OUT;
              end
            end
            bls_pkg::OP_CLEAR: begin
              cmd_o.clear = 1'b1;
              fin         = 1'b1;
            end
            bls_pkg::OP_REVERSE: begin
              if (sts_i.cnt_gt1) begin
                cmd_o.rev_init = 1'b1;
                state_d        = bls_pkg::ST_REV_WLO;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      bls_pkg::ST_POP_OUT: begin
        // read data from the top entry is ready and held until the result leaves
        if (sts_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.out_rd_ram = 1'b1;
          cmd_o.pop_dec    = is_pop_q;
          state_d          = bls_pkg::ST_IDLE;
        end
      end
      bls_pkg::ST_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_err  = err_q;
          state_d        = bls_pkg::ST_IDLE;
        end
      end
      bls_pkg::ST_REV_WLO: begin
        cmd_o.rev_wlo = 1'b1;
        state_d       = bls_pkg::ST_REV_WHI;
      end
      bls_pkg::ST_REV_WHI: begin
        cmd_o.rev_whi = 1'b1;
        if (sts_i.rev_more) begin
          cmd_o.rev_next = 1'b1;
          state_d        = bls_pkg::ST_REV_WLO;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        state_d = bls_pkg::ST_IDLE;
      end
    endcase

    // result with no read data: send now if the output register is free
    if (fin) begin
      if (sts_i.out_free) begin
        cmd_o.load_out = 1'b1;
        cmd_o.out_err  = fin_err;
        state_d        = bls_pkg::ST_IDLE;
      end else begin
        err_d   = fin_err;
        state_d = bls_pkg::ST_HOLD;
      end
    end
  end

endmodule

>>> src/bls_datapath.sv
// Datapath for the bounded LIFO stack: count, swap pointers, entry RAM, output register.
// Depends on bls_pkg and bls_ram.
module bls_datapath #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bls_pkg::cmd_t                   cmd_i,
  output bls_pkg::sts_t                   sts_o,
  input  logic [bls_pkg::PD_W-1:0]        push_data_i,
  input  logic                            cfg_we_i,
  input  logic [bls_pkg::CAP_W-1:0]       cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bls_pkg::RD_W-1:0]        out_read_data_o,
  output logic [bls_pkg::ERR_W-1:0]       out_error_code_o,
  output logic [bls_pkg::CNT_W-1:0]       out_entry_count_o,
  output logic                            out_is_empty_o,
  output logic                            out_is_full_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [bls_pkg::CAP_W-1:0] cap_q;
  logic [CW-1:0]             count_q, count_d;
  logic [AW-1:0]             lo_q, lo_d, hi_q, hi_d;
  logic [DATA_WIDTH-1:0]     tmp_q;

  // RAM ports
  logic                  we, re_a, re_b;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b, push_word;
  logic [63:0]           push64, rd64;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= bls_pkg::CAP_RESET;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.rev_wlo) begin
      tmp_q <= rdata_a;
    end
  end

  // effective limit: capacity saturated to 1..DEPTH
  logic [31:0] cap32, lim32, cnt32, cntd32;
  logic [CW-1:0] cnt_m1;

  always_comb begin
    cap32 = 32'(cap_q);
    if (cap32 == 32'd0) begin
      lim32 = 32'd1;
    end else if (cap32 > 32'(DEPTH)) begin
      lim32 = 32'(DEPTH);
    end else begin
      lim32 = cap32;
    end
  end

  assign cnt32  = 32'(count_q);
  assign cnt_m1 = count_q - 1'b1;

  always_comb begin
    priority if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop_dec) begin
      count_d = cnt_m1;
    end else begin
      count_d = count_q;
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.rev_init) begin
      lo_d = '0;
      hi_d = cnt_m1[AW-1:0];
    end else if (cmd_i.rev_whi) begin
      lo_d = lo_q + 1'b1;
      hi_d = hi_q - 1'b1;
    end
  end

  assign push64    = 64'(push_data_i);
  assign push_word = push64[DATA_WIDTH-1:0];

  always_comb begin
    we    = cmd_i.push | cmd_i.rev_wlo | cmd_i.rev_whi;
    waddr = count_q[AW-1:0];
    wdata = push_word;
    if (cmd_i.rev_wlo) begin
      waddr = lo_q;
      wdata = rdata_b;
    end else if (cmd_i.rev_whi) begin
      waddr = hi_q;
      wdata = tmp_q;
    end

    re_a    = cmd_i.rd_top | cmd_i.rev_init | cmd_i.rev_next;
    re_b    = cmd_i.rev_init | cmd_i.rev_next;
    raddr_a = cnt_m1[AW-1:0];
    raddr_b = cnt_m1[AW-1:0];
    if (cmd_i.rev_init) begin
      raddr_a = '0;
    end else if (cmd_i.rev_next) begin
      raddr_a = lo_q + 1'b1;
      raddr_b = hi_q - 1'b1;
    end
  end

  bls_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (re_a),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (re_b),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // output register
  logic                        out_valid_q;
  logic [bls_pkg::RD_W-1:0]    out_rd_q;
  logic [bls_pkg::ERR_W-1:0]   out_err_q;
  logic [bls_pkg::CNT_W-1:0]   out_cnt_q;
  logic                        out_empty_q, out_full_q;

  assign rd64   = 64'(rdata_a);
  assign cntd32 = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rd_q    <= cmd_i.out_rd_ram ? rd64[bls_pkg::RD_W-1:0] : '0;
      out_err_q   <= cmd_i.out_err;
      out_cnt_q   <= cntd32[bls_pkg::CNT_W-1:0];
      out_empty_q <= (count_d == '0);
      out_full_q  <= (cntd32 >= lim32);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_read_data_o   = out_rd_q;
  assign out_error_code_o  = out_err_q;
  assign out_entry_count_o = out_cnt_q;
  assign out_is_empty_o    = out_empty_q;
  assign out_is_full_o     = out_full_q;

  // status
  logic [AW:0] lo_ext, hi_ext;
  assign lo_ext = {1'b0, lo_q};
  assign hi_ext = {1'b0, hi_q};

  always_comb begin
    sts_o.empty    = (count_q == '0);
    sts_o.full     = (cnt32 >= lim32);
    sts_o.cnt_gt1  = (cnt32 > 32'd1);
    sts_o.rev_more = ((lo_ext + 2'd2) < hi_ext);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  a_push_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("push did not advance the count");

  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rev_wlo |-> (lo_q < hi_q))
    else $error("swap pointers crossed");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending transaction");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (cnt32 < lim32))
    else $error("push accepted beyond the limit");

endmodule

>>> src/bounded_lifo_stack.sv
// Bounded LIFO stack, top level: stream ports, controller and datapath.
// Depends on bls_pkg, bls_ctrl, bls_datapath (and bls_ram below it).
//
// Usage: each input transaction on s_axis is one operation (push, pop, peek,
// clear, reverse); each yields exactly one result transaction on m_axis with
// read data, error code, entry count and empty/full flags after the operation.
// Steps from acceptance to result:
//   push, clear, errors, unknown ops: result loaded on acceptance or in ST_HOLD
//   pop, peek: registered RAM read of the top entry, then loaded in ST_POP_OUT
//   reverse of n entries: floor(n / 2) swaps, each written in ST_REV_WLO then
//   ST_REV_WHI, as the RAM has a single write port
// A new operation is taken once the previous one has placed its result.
// The result sits in an output register, so one operation may be taken and
// finished while a result waits; its own result then holds the controller
// until m_axis_tready_i frees the register.
// Reset empties the stack and sets the capacity register to 100; the entry
// RAM is not cleared and needs no init pass. Write cfg only while idle.
module bounded_lifo_stack #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [2:0] op, [34:3] push_data, [39:35] zero
  input  logic [bls_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [31:0] read_data, [33:32] error_code, [41:34] entry_count,
  // [42] is_empty, [43] is_full, [47:44] zero
  output logic [bls_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [bls_pkg::CAP_W-1:0]         cfg_wdata_i
);

  bls_pkg::cmd_t cmd;
  bls_pkg::sts_t sts;

  logic [bls_pkg::RD_W-1:0]  read_data;
  logic [bls_pkg::ERR_W-1:0] error_code;
  logic [bls_pkg::CNT_W-1:0] entry_count;
  logic                      is_empty, is_full;

  bls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .op_i       (s_axis_tdata_i[bls_pkg::OP_W-1:0]),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bls_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .push_data_i       (s_axis_tdata_i[bls_pkg::OP_W +: bls_pkg::PD_W]),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .out_read_data_o   (read_data),
    .out_error_code_o  (error_code),
    .out_entry_count_o (entry_count),
    .out_is_empty_o    (is_empty),
    .out_is_full_o     (is_full)
  );

  assign m_axis_tdata_o = {4'b0000, is_full, is_empty, entry_count, error_code, read_data};

endmodule

>>> dv/bounded_lifo_stack_tb.sv
// Self-checking testbench for bounded_lifo_stack: random and directed stack operations on
// s_axis, with a class-based stack predictor checking every m_axis result field by field.
// Depends on bls_pkg and the bounded_lifo_stack RTL.
`timescale 1ns / 1ps

module bounded_lifo_stack_tb;

  localparam int unsigned DEPTH        = 128;
  localparam int unsigned DATA_WIDTH   = 32;
  localparam int unsigned MAX_GAP      = 14;
  localparam int unsigned RX_HOLD_CYC  = 400;
  localparam int unsigned SETTLE_CYC   = 4;
  localparam int unsigned LIMIT_CYC    = 2_000_000;
  localparam int unsigned PHASE_ITEMS  = 192;
  localparam int unsigned CHUNK_ITEMS  = 48;
  localparam int unsigned OPW          = bls_pkg::OP_W;
  localparam int unsigned FIELD_W      = bls_pkg::RD_W;
  localparam logic [bls_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [bls_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic [bls_pkg::RD_W-1:0]  rd;
    logic [bls_pkg::ERR_W-1:0] err;
    logic [bls_pkg::CNT_W-1:0] cnt;
    logic                      empty;
    logic                      full;
  } stack_status_t;

  // Predicts stack status per operation and matches it against m_axis transactions.
  class lifo_scoreboard;
    logic [DATA_WIDTH-1:0]     words [DEPTH];
    int unsigned               fill;
    logic [bls_pkg::CAP_W-1:0] cap;
    stack_status_t             status_q[$];
    int unsigned               mismatch_cnt;

    function void reset_state();
      fill = 0;
      cap = bls_pkg::CAP_RESET;
      mismatch_cnt = 0;
    endfunction

    function void set_limit(logic [bls_pkg::CAP_W-1:0] v);
      cap = v;
    endfunction

    function int unsigned eff_limit();
      if (cap == 0) return 1;
      if (cap > DEPTH) return DEPTH;
      return 32'(cap);
    endfunction

    function void apply_op(logic [bls_pkg::OP_W-1:0] op, logic [bls_pkg::PD_W-1:0] data);
      stack_status_t     s;
      int unsigned       lim;
      int unsigned       lo;
      int unsigned       hi;
      logic [DATA_WIDTH-1:0] t;
      lim = eff_limit();
      s.rd = '0;
      s.err = bls_pkg::ERR_OK;
      case (op)
        bls_pkg::OP_PUSH: begin
          if (fill >= lim) s.err = bls_pkg::ERR_FULL;
          else begin
            words[fill] = data;
            fill++;
          end
        end
        bls_pkg::OP_POP, bls_pkg::OP_PEEK: begin
          if (fill == 0) s.err = bls_pkg::ERR_EMPTY;
          else begin
            s.rd = words[fill-1];
            if (op == bls_pkg::OP_POP) fill--;
          end
        end
        bls_pkg::OP_CLEAR: fill = 0;
        bls_pkg::OP_REVERSE: begin
          if (fill > 1) begin
            lo = 0;
            hi = fill - 1;
            while (lo < hi) begin
              t = words[lo];
              words[lo] = words[hi];
              words[hi] = t;
              lo++;
              hi--;
            end
          end
        end
        default: ;
      endcase
      s.cnt = fill[bls_pkg::CNT_W-1:0];
      s.empty = (fill == 0);
      s.full = (fill >= lim);
      status_q.push_back(s);
    endfunction

    function void cmp_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatch_cnt++;
      end
    endfunction

    function void check_result(logic [bls_pkg::M_TDATA_W-1:0] beat);
      stack_status_t want;
      if (status_q.size() == 0) begin
        $display("%0t: result with no operation outstanding, expected none, actual %0h",
                 $time, beat);
        mismatch_cnt++;
        return;
      end
      want = status_q.pop_front();
      cmp_field("read_data", want.rd, beat[31:0]);
      cmp_field("error_code", FIELD_W'(want.err), FIELD_W'(beat[33:32]));
      cmp_field("entry_count", FIELD_W'(want.cnt), FIELD_W'(beat[41:34]));
      cmp_field("is_empty", FIELD_W'(want.empty), FIELD_W'(beat[42]));
      cmp_field("is_full", FIELD_W'(want.full), FIELD_W'(beat[43]));
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_tvalid;
  logic                            s_axis_tready_o;
  logic [bls_pkg::S_TDATA_W-1:0]   s_tdata;
  logic                            m_axis_tvalid_o;
  logic                            m_tready;
  logic [bls_pkg::M_TDATA_W-1:0]   m_axis_tdata_o;
  logic                            cfg_we;
  logic [bls_pkg::CAP_W-1:0]       cfg_wdata;

  lifo_scoreboard lifo_sb;
  bit             tx_burst;
  bit             rx_hold_req;

  bounded_lifo_stack #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT_CYC) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // One operation transaction; gap drawn per item unless in a burst stretch.
  task automatic drive_op(input logic [bls_pkg::OP_W-1:0] op,
                          input logic [bls_pkg::PD_W-1:0] data);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(bls_pkg::S_TDATA_W-bls_pkg::OP_W-bls_pkg::PD_W){1'b0}}, data, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    lifo_sb.apply_op(op, data);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (lifo_sb.status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [bls_pkg::CAP_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    lifo_sb.set_limit(v);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [bls_pkg::PD_W-1:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // push_bias skews toward pushes so the stack runs deep; otherwise toward pops
  function automatic logic [bls_pkg::OP_W-1:0] rand_op(input bit push_bias);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (push_bias) begin
      if (r < 70) return bls_pkg::OP_PUSH;
      if (r < 82) return bls_pkg::OP_POP;
      if (r < 89) return bls_pkg::OP_PEEK;
      if (r < 95) return bls_pkg::OP_REVERSE;
      if (r < 96) return bls_pkg::OP_CLEAR;
    end else begin
      if (r < 25) return bls_pkg::OP_PUSH;
      if (r < 65) return bls_pkg::OP_POP;
      if (r < 80) return bls_pkg::OP_PEEK;
      if (r < 90) return bls_pkg::OP_REVERSE;
      if (r < 93) return bls_pkg::OP_CLEAR;
    end
    return OPW'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
  endfunction

  // Result sink: random backpressure, burst stretches, and one long hold on request.
  initial begin
    int unsigned hold;
    int unsigned n;
    bit          rx_burst;
    m_tready = 1'b0;
    rx_burst = 1'b0;
    n = 0;
    @(posedge rst_ni);
    forever begin
      if (n % CHUNK_ITEMS == 0) rx_burst = ($urandom_range(0, 3) == 0);
      n++;
      if (rx_hold_req) begin
        hold = RX_HOLD_CYC;
        rx_hold_req = 1'b0;
      end else begin
        hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      lifo_sb.check_result(m_axis_tdata_o);
    end
  end

  initial begin
    logic [bls_pkg::CAP_W-1:0] caps [10];
    bit                        bias;
    lifo_sb = new();
    lifo_sb.reset_state();
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    tx_burst = 1'b0;
    rx_hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty errors, one-entry reverse, extremes, unknown ops
    drive_op(bls_pkg::OP_POP, '0);
    drive_op(bls_pkg::OP_PEEK, '0);
    drive_op(bls_pkg::OP_REVERSE, '0);
    drive_op(bls_pkg::OP_PUSH, '0);
    drive_op(bls_pkg::OP_REVERSE, '0);
    drive_op(bls_pkg::OP_PUSH, '1);
    drive_op(bls_pkg::OP_PUSH, 32'h1234_5678);
    drive_op(bls_pkg::OP_PUSH, 32'hA5A5_A5A5);
    drive_op(bls_pkg::OP_REVERSE, '0);
    drive_op(bls_pkg::OP_POP, '0);
    drive_op(bls_pkg::OP_PEEK, '0);
    for (int o = OP_UNUSED_FIRST; o <= OP_UNUSED_LAST; o++) drive_op(o[OPW-1:0], '1);
    drive_op(bls_pkg::OP_CLEAR, '0);
    drive_op(bls_pkg::OP_POP, '0);
    // smallest limit: full after one push
    write_limit(8'd1);
    drive_op(bls_pkg::OP_PUSH, 32'h5A5A_5A5A);
    drive_op(bls_pkg::OP_PUSH, '1);
    drive_op(bls_pkg::OP_POP, '0);
    // limit lowered below the count: nothing dropped, pushes refused
    write_limit(8'd128);
    drive_op(bls_pkg::OP_PUSH, 32'h0000_0001);
    drive_op(bls_pkg::OP_PUSH, 32'h8000_0000);
    drive_op(bls_pkg::OP_PUSH, 32'hFFFF_FFFE);
    write_limit(8'd2);
    drive_op(bls_pkg::OP_PUSH, '1);
    drive_op(bls_pkg::OP_POP, '0);
    drive_op(bls_pkg::OP_POP, '0);
    drive_op(bls_pkg::OP_PUSH, 32'hDEAD_BEEF);

    caps = '{8'd128, 8'd0, 8'd255, 8'd5, 8'd100, 8'd2, 8'd64,
             8'($urandom_range(1, 128)), 8'd1, 8'd200};
    for (int p = 0; p < 10; p++) begin
      write_limit(caps[p]);
      // sink stalls while pushes keep coming, so the block backs up
      if (p == 0) rx_hold_req = 1'b1;
      bias = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % CHUNK_ITEMS == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          bias = (p == 0 && i < 160) ? 1'b1 : 1'($urandom_range(0, 1));
        end
        drive_op(rand_op(bias), rand_word());
      end
    end

    wait_drained();
    if (lifo_sb.mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
